### sv/framebuffer_text_renderer_core_macros.svh
// Assertion macros shared by the renderer checker.
`ifndef FRAMEBUFFER_TEXT_RENDERER_CORE_MACROS_SVH
`define FRAMEBUFFER_TEXT_RENDERER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FBTR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FBTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fbtr_pkg.sv
// Shared types, action codes and the 5x8 font ROM of the text renderer.
package fbtr_pkg;

    // Action codes
    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_PIXEL = 3'd1;
    localparam logic [2:0] ACT_CHAR  = 3'd2;
    localparam logic [2:0] ACT_MSG   = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // Printable code range covered by the font
    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd127;

    // A glyph is five columns, each column touches up to two page bytes
    localparam int GLYPH_W   = 5;
    localparam int GLYPH_OPS = 2 * GLYPH_W;
    localparam int OP_CNT_W  = 4;
    localparam int FONT_IDX_W = 7;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       pixel_color;
        logic [7:0] char_code;
        logic       message_start;
        logic [8:0] byte_index;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_char;
    } out_t;

    // One store access: address valid, write back, capture read, bit masks
    typedef struct packed {
        logic       valid;
        logic       wr;
        logic       rd;
        logic [7:0] set_bits;
        logic [7:0] clr_bits;
    } op_t;

    // Column 0 in [39:32], column 4 in [7:0]; bit 0 of a column is its top row
    localparam logic [39:0] FONT_ROM [96] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0006090906
    };

endpackage

### sv/fbtr_opgen.sv
// Store access generator: maps an action and op count to a byte address and masks.
module fbtr_opgen #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 32,
    localparam int PAGES        = SCREEN_HEIGHT / 8,
    localparam int STORE_BYTES  = SCREEN_WIDTH * PAGES,
    localparam int ADDR_W       = $clog2(STORE_BYTES)
) (
    input  logic [2:0]                    act,
    input  logic [7:0]                    x_base,
    input  logic [7:0]                    y_base,
    input  logic                          color,
    input  logic [39:0]                   glyph,
    input  logic [8:0]                    byte_index,
    input  logic [fbtr_pkg::OP_CNT_W-1:0] op_cnt,
    output logic [ADDR_W-1:0]             addr,
    output fbtr_pkg::op_t                 op
);
    import fbtr_pkg::*;

    logic [2:0]  col;
    logic        half;
    logic [7:0]  col_bits;
    logic [15:0] spread;
    logic [7:0]  pix_bit;
    logic [7:0]  px;
    logic [4:0]  page;
    logic        on_screen;

    // Glyph column select, split across the two pages it may straddle
    always_comb
    begin
        col  = op_cnt[3:1];
        half = op_cnt[0];
        case (col)
            3'd0:    col_bits = glyph[39:32];
            3'd1:    col_bits = glyph[31:24];
            3'd2:    col_bits = glyph[23:16];
            3'd3:    col_bits = glyph[15:8];
            3'd4:    col_bits = glyph[7:0];
            default: col_bits = '0;
        endcase
        spread  = {8'b0, col_bits} << y_base[2:0];
        pix_bit = 8'b1 << y_base[2:0];
    end

    // Access decode
    always_comb
    begin
        op   = '0;
        px   = x_base;
        page = y_base[7:3];
        unique case (act) inside
            ACT_CHAR, ACT_MSG:
            begin
                px          = x_base + 8'(col);
                page        = y_base[7:3] + 5'(half);
                op.wr       = 1'b1;
                op.set_bits = half ? spread[15:8] : spread[7:0];
            end
            ACT_PIXEL:
            begin
                op.wr       = 1'b1;
                op.set_bits = color ? pix_bit : 8'b0;
                op.clr_bits = color ? 8'b0 : pix_bit;
            end
            ACT_READ:
            begin
                op.rd = 1'b1;
            end
            default:
            begin
                op.wr = 1'b0;
            end
        endcase

        // Off-screen columns and rows in a partial last page are dropped
        on_screen = (32'(px) < 32'(SCREEN_WIDTH)) && (32'(page) < 32'(PAGES));
        if (act == ACT_READ)
        begin
            addr     = ADDR_W'(byte_index);
            op.valid = 32'(byte_index) < 32'(STORE_BYTES);
        end
        else
        begin
            addr     = ADDR_W'(32'(page) * 32'(SCREEN_WIDTH) + 32'(px));
            op.valid = on_screen;
        end
    end

endmodule

### sv/framebuffer_text_renderer_core.sv
// One word is in flight at a time, with one store access per cycle while an item runs.
// A glyph costs ten store accesses, two page bytes for each of five columns.
// After reset a clearing pass zeroes all STORE_BYTES bytes of the store (512 at 128x32),
// one byte a cycle, with in_ready low; message counters reset to zero.
module framebuffer_text_renderer_core #(
    parameter int SCREEN_WIDTH   = 128,
    parameter int SCREEN_HEIGHT  = 32,
    parameter int CHARS_PER_LINE = 25
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fbtr_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output fbtr_pkg::out_t out_data
);
    import fbtr_pkg::*;

    localparam int PAGES       = SCREEN_HEIGHT / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = (CHARS_PER_LINE > 1) ? $clog2(CHARS_PER_LINE) : 1;
    localparam logic [ADDR_W-1:0]   CLR_LAST = ADDR_W'(STORE_BYTES - 1);
    localparam logic [OP_CNT_W-1:0] GLYPH_LAST = OP_CNT_W'(GLYPH_OPS - 1);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RUN, S_FLUSH, S_FINISH} state_t;

    // Control state
    state_t              state_reg, state_next;
    logic [OP_CNT_W-1:0] op_cnt_reg, op_cnt_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                clr_res_reg, clr_res_next;
    logic [COL_W-1:0]    text_col_reg, text_col_next;
    logic [7:0]          text_off_reg, text_off_next;
    logic                s2_valid_reg, s2_valid_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;

    // Item and stage-two payload
    logic [2:0]        act_reg;
    logic [7:0]        x_base_reg;
    logic [7:0]        y_base_reg;
    logic              color_reg;
    logic [39:0]       glyph_reg;
    logic [8:0]        index_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    op_t               s2_op_reg;
    logic [7:0]        res_data_reg;
    logic              res_bad_reg;

    // Frame store
    logic [7:0]        store_mem [STORE_BYTES];
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    // Access generator outputs
    logic [ADDR_W-1:0] op_addr;
    op_t               op;

    // Accept-side decode
    logic                  accept;
    logic                  char_ok;
    logic [FONT_IDX_W-1:0] font_idx;
    logic [39:0]           glyph_lookup;
    logic [COL_W-1:0]      col_start;
    logic [COL_W-1:0]      col_after;
    logic [7:0]            off_start;
    logic [7:0]            off_eff;
    logic [7:0]            col8;
    logic [7:0]            msg_x;
    logic [7:0]            msg_y;
    logic [OP_CNT_W-1:0]   op_last;

    fbtr_opgen #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_opgen (
        .act        (act_reg),
        .x_base     (x_base_reg),
        .y_base     (y_base_reg),
        .color      (color_reg),
        .glyph      (glyph_reg),
        .byte_index (index_reg),
        .op_cnt     (op_cnt_reg),
        .addr       (op_addr),
        .op         (op)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Font lookup and message placement
    always_comb
    begin
        char_ok      = (in_data.char_code >= FIRST_CODE) && (in_data.char_code <= LAST_CODE);
        font_idx     = FONT_IDX_W'(in_data.char_code - FIRST_CODE);
        glyph_lookup = char_ok ? FONT_ROM[font_idx] : '0;

        col_start = in_data.message_start ? '0 : text_col_reg;
        off_start = in_data.message_start ? 8'd0 : text_off_reg;
        off_eff   = (col_start == '0) ? off_start + 8'd8 : off_start;
        col_after = (32'(col_start) + 32'd1 >= 32'(CHARS_PER_LINE))
                    ? '0 : COL_W'(32'(col_start) + 32'd1);
        col8      = 8'(col_start);
        msg_x     = in_data.x_pos + (col8 << 2) + col8;
        msg_y     = in_data.y_pos + off_eff;

        op_last = ((act_reg == ACT_CHAR) || (act_reg == ACT_MSG)) ? GLYPH_LAST : '0;
    end

    // Store write port: clearing sweep or stage-two write-back
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 8'd0;
        end
        else
        begin
            wr_en   = s2_valid_reg && s2_op_reg.valid && s2_op_reg.wr;
            wr_addr = s2_addr_reg;
            wr_data = (rd_data_reg | s2_op_reg.set_bits) & ~s2_op_reg.clr_bits;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_cnt_next    = op_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_res_next   = clr_res_reg;
        text_col_next  = text_col_reg;
        text_off_next  = text_off_reg;
        s2_valid_next  = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_cnt_next = '0;
                    clr_res_next = 1'b0;
                    state_next   = clr_res_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_cnt_next = '0;
                    unique case (in_data.action) inside
                        ACT_CLEAR:
                        begin
                            clr_res_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        ACT_PIXEL, ACT_READ:
                        begin
                            state_next = S_RUN;
                        end
                        ACT_CHAR:
                        begin
                            state_next = char_ok ? S_RUN : S_FINISH;
                        end
                        ACT_MSG:
                        begin
                            text_col_next = col_after;
                            text_off_next = off_eff;
                            state_next    = char_ok ? S_RUN : S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                s2_valid_next = 1'b1;
                if (op_cnt_reg == op_last)
                    state_next = S_FLUSH;
                else
                    op_cnt_next = op_cnt_reg + OP_CNT_W'(1);
            end
            S_FLUSH:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.read_data = res_data_reg;
                    out_data_next.bad_char  = res_bad_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_cnt_reg    <= '0;
            clr_cnt_reg   <= '0;
            clr_res_reg   <= 1'b0;
            text_col_reg  <= '0;
            text_off_reg  <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_cnt_reg    <= op_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_res_reg   <= clr_res_next;
            text_col_reg  <= text_col_next;
            text_off_reg  <= text_off_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Item capture, stage-two pipeline and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= in_data.action;
            x_base_reg   <= (in_data.action == ACT_MSG) ? msg_x : in_data.x_pos;
            y_base_reg   <= (in_data.action == ACT_MSG) ? msg_y : in_data.y_pos;
            color_reg    <= in_data.pixel_color;
            glyph_reg    <= glyph_lookup;
            index_reg    <= in_data.byte_index;
            res_data_reg <= 8'd0;
            res_bad_reg  <= ((in_data.action == ACT_CHAR) || (in_data.action == ACT_MSG))
                            && !char_ok;
        end
        else if (s2_valid_reg && s2_op_reg.valid && s2_op_reg.rd)
        begin
            res_data_reg <= rd_data_reg;
        end
        s2_addr_reg <= op_addr;
        s2_op_reg   <= op;
    end

    // Frame store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rd_data_reg <= store_mem[op_addr];
    end

endmodule

### sv/fbtr_checker.sv
// Port-level checker for the text renderer, bound to the top level.
module fbtr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input fbtr_pkg::out_t out_data
);
    import fbtr_pkg::*;

`include "framebuffer_text_renderer_core_macros.svh"

    // A stalled output word holds its value
    `FBTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word dropped or changed while stalled")

    // One word in flight: ready falls right after an accept
    `FBTR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input accepted while a word is in flight")

    // A flagged code never carries read data
    `FBTR_ASSERT_NOW(a_bad_no_data, out_valid && out_data.bad_char, out_data.read_data == 8'd0, "bad_char word carries read data")

    // No result appears in the cycle right after an accept
    `FBTR_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result appeared too early after accept")

endmodule

bind framebuffer_text_renderer_core fbtr_checker u_fbtr_checker (.*);
